>>> hw/rtl/chdg_pkg.sv
// Shared constants and codes for the chart DAC channel generator.
package chdg_pkg;

	localparam int DAC_BITS = 12;
	localparam int CODE_W   = 16;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 3;
	localparam int SMP_W    = 32;
	localparam int SPAN_W   = 32;
	localparam int MAG_W    = 34 + DAC_BITS;

	localparam logic [CODE_W-1:0] DAC_TOP_CODE  = CODE_W'((1 << DAC_BITS) - 1);
	localparam logic [CODE_W-1:0] DAC_HALF_CODE = CODE_W'(1 << (DAC_BITS - 1));

	localparam logic [2:0] MODE_DATA   = 3'd0;
	localparam logic [2:0] MODE_QUANTA = 3'd1;
	localparam logic [2:0] MODE_RAMP   = 3'd2;
	localparam logic [2:0] MODE_FULL   = 3'd3;

	localparam logic [2:0] STYPE_U8  = 3'd0;
	localparam logic [2:0] STYPE_U16 = 3'd1;
	localparam logic [2:0] STYPE_U32 = 3'd2;
	localparam logic [2:0] STYPE_S8  = 3'd3;
	localparam logic [2:0] STYPE_S16 = 3'd4;
	localparam logic [2:0] STYPE_S32 = 3'd5;

	localparam logic [IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [IDX_W-1:0] REG_MODE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_CLAMP  = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX    = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIN    = 3'd4;
	localparam logic [IDX_W-1:0] REG_STEP   = 3'd5;
	localparam logic [IDX_W-1:0] REG_RAW    = 3'd6;
	localparam logic [IDX_W-1:0] REG_STYPE  = 3'd7;

endpackage

>>> hw/rtl/chdg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module chdg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [chdg_pkg::MAG_W-1:0]  dividend,
	input  logic [chdg_pkg::SPAN_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [chdg_pkg::MAG_W-1:0]  quotient
);
	import chdg_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  quo_q;
	logic [SPAN_W-1:0] rem_q;
	logic [SPAN_W-1:0] dvs_q;
	logic [SPAN_W:0]   partial;
	logic [SPAN_W:0]   trial;
	logic              ge;

	assign partial = {rem_q, quo_q[MAG_W-1]};
	assign ge      = partial >= {1'b0, dvs_q};
	assign trial   = partial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_W-2:0], ge};
			rem_q <= ge ? trial[SPAN_W-1:0] : partial[SPAN_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |=> rem_q < dvs_q)
		else $error("divider remainder out of range");

endmodule

>>> hw/rtl/chart_dac_channel_generator.sv
// Top level of one chart-recorder DAC channel generator.
// In quanta, ramp, full-scale and zero modes and for an absent sample a request
// goes to the hold state, then the output register; a scaled sample first runs
// prepare, multiply, bit-serial divide (one quotient bit per cycle) and post.
// One request at a time; the next is taken once the current one is finished.
// arst_n clears control state and loads the register reset values.
module chart_dac_channel_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [chdg_pkg::SMP_W-1:0]  s_tdata,   // sample_bits[31:0]
	input  logic [0:0]                  s_tuser,   // sample_present[0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [chdg_pkg::CODE_W-1:0] m_tdata,   // dac_code[15:0]
	input  logic                        cfg_we,
	input  logic [chdg_pkg::IDX_W-1:0]  cfg_index,
	input  logic [chdg_pkg::CFG_W-1:0]  cfg_wdata
);
	import chdg_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_POST = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic                enable_q;
	logic [2:0]          mode_q;
	logic                clamp_q;
	logic signed [31:0]  max_q;
	logic signed [31:0]  min_q;
	logic [15:0]         step_q;
	logic [15:0]         raw_q;
	logic [2:0]          stype_q;
	logic [DAC_BITS-1:0] ramp_q;

	logic [2:0]          state_q;
	logic [33:0]         diff_q;
	logic [32:0]         span_q;
	logic [32:0]         mag_q;
	logic [SPAN_W-1:0]   dvs_q;
	logic                neg_q;
	logic [CODE_W-1:0]   code_q;
	logic                out_valid_q;
	logic [CODE_W-1:0]   out_data_q;

	logic                accept;
	logic [32:0]         smp_ext;
	logic [DAC_BITS-1:0] ramp_next;
	logic [32:0]         span_abs;
	logic [MAG_W-1:0]    prod;
	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic [MAG_W-1:0]    quo;
	logic [MAG_W-1:0]    quo_neg;
	logic [CODE_W-1:0]   post_code;
	logic                out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign ramp_next = ramp_q + step_q[DAC_BITS-1:0];

	always_comb begin
		unique case (stype_q)
			STYPE_U8:  smp_ext = {25'd0, s_tdata[7:0]};
			STYPE_U16: smp_ext = {17'd0, s_tdata[15:0]};
			STYPE_U32: smp_ext = {1'b0, s_tdata};
			STYPE_S8:  smp_ext = {{25{s_tdata[7]}}, s_tdata[7:0]};
			STYPE_S16: smp_ext = {{17{s_tdata[15]}}, s_tdata[15:0]};
			default:   smp_ext = {s_tdata[31], s_tdata};
		endcase
	end

	assign span_abs  = span_q[32] ? (33'd0 - span_q) : span_q;
	assign prod      = {{(MAG_W-33-DAC_BITS){1'b0}}, mag_q, {DAC_BITS{1'b0}}}
	                 - {{(MAG_W-33){1'b0}}, mag_q};
	assign div_start = (state_q == ST_MUL);
	assign quo_neg   = '0 - quo;

	always_comb begin
		if (clamp_q) begin
			priority if (neg_q)
				post_code = '0;
			else if (quo > MAG_W'(DAC_TOP_CODE))
				post_code = DAC_TOP_CODE;
			else
				post_code = quo[CODE_W-1:0];
		end else begin
			post_code = {{(CODE_W-DAC_BITS){1'b0}},
			             neg_q ? quo_neg[DAC_BITS-1:0] : quo[DAC_BITS-1:0]};
		end
	end

	chdg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (dvs_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			mode_q   <= MODE_DATA;
			clamp_q  <= 1'b1;
			max_q    <= 32'sd1;
			min_q    <= 32'sd1;
			step_q   <= '0;
			raw_q    <= '0;
			stype_q  <= STYPE_S32;
			ramp_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE: enable_q <= cfg_wdata[0];
					REG_MODE: begin
						mode_q <= cfg_wdata[2:0];
						ramp_q <= '0;
					end
					REG_CLAMP: clamp_q <= cfg_wdata[0];
					REG_MAX:   max_q   <= cfg_wdata;
					REG_MIN:   min_q   <= cfg_wdata;
					REG_STEP:  step_q  <= cfg_wdata[15:0];
					REG_RAW:   raw_q   <= cfg_wdata[15:0];
					REG_STYPE: stype_q <= cfg_wdata[2:0];
					default: ;
				endcase
			end else if (accept && enable_q && mode_q == MODE_RAMP) begin
				ramp_q <= ramp_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && enable_q) begin
						if (mode_q == MODE_DATA && s_tuser[0])
							state_q <= ST_PREP;
						else
							state_q <= ST_HOLD;
					end
				end
				ST_PREP: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_POST;
				end
				ST_POST: state_q <= ST_HOLD;
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q <= {smp_ext[32], smp_ext} - {{2{min_q[31]}}, min_q};
			span_q <= {max_q[31], max_q} - {min_q[31], min_q};
			priority case (mode_q)
				MODE_DATA:   code_q <= DAC_HALF_CODE;
				MODE_QUANTA: code_q <= raw_q;
				MODE_RAMP:   code_q <= {{(CODE_W-DAC_BITS){1'b0}}, ramp_next};
				MODE_FULL:   code_q <= DAC_TOP_CODE;
				default:     code_q <= '0;
			endcase
		end
		if (state_q == ST_PREP) begin
			neg_q <= diff_q[33];
			mag_q <= diff_q[33] ? 33'(34'd0 - diff_q) : diff_q[32:0];
			dvs_q <= (span_abs == 33'd0) ? SPAN_W'(1) : span_abs[SPAN_W-1:0];
		end
		if (state_q == ST_POST)
			code_q <= post_code;
		if (state_q == ST_HOLD && out_free)
			out_data_q <= code_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !enable_q |=> state_q == ST_IDLE)
		else $error("disabled channel started work");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && !div_done |-> div_busy)
		else $error("divide state without running divider");
	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POST && clamp_q |=> code_q <= DAC_TOP_CODE)
		else $error("clamped code out of range");

endmodule
